// ===== sv/ksd_pkg.sv =====
// ----------------------------------------------------------------------------
// ksd_pkg
// Shared constants for the keyboard scancode decoder: set-1 scancodes,
// event codes and the Nordic CP437 layout tables.
// ----------------------------------------------------------------------------
package ksd_pkg;

  localparam int unsigned ScWidth    = 8;
  localparam int unsigned EventWidth = 3;
  localparam int unsigned CharWidth  = 8;
  localparam int unsigned TableLen   = 90;
  localparam int unsigned TableIdxW  = $clog2(TableLen);

  localparam int unsigned InDataWidth  = 8;
  localparam int unsigned OutDataWidth = 16;

  typedef logic [ScWidth-1:0]    scancode_t;
  typedef logic [EventWidth-1:0] key_event_t;
  typedef logic [CharWidth-1:0]  char_t;

  // Set-1 scancodes
  localparam scancode_t SC_LSHIFT_MAKE   = 8'h2A;
  localparam scancode_t SC_LSHIFT_BREAK  = 8'hAA;
  localparam scancode_t SC_RSHIFT_MAKE   = 8'h36;
  localparam scancode_t SC_RSHIFT_BREAK  = 8'hB6;
  localparam scancode_t SC_LCTRL_MAKE    = 8'h1D;
  localparam scancode_t SC_LCTRL_BREAK   = 8'h9D;
  localparam scancode_t SC_CAPS_MAKE     = 8'h3A;
  localparam scancode_t SC_X_MAKE        = 8'h2D;
  localparam scancode_t SC_ENTER_MAKE    = 8'h1C;
  localparam scancode_t SC_DELETE_MAKE   = 8'h53;
  localparam scancode_t SC_LEFT_MAKE     = 8'h4B;
  localparam scancode_t SC_RIGHT_MAKE    = 8'h4D;
  localparam scancode_t SC_BKSP_MAKE     = 8'h0E;

  // Event codes
  localparam key_event_t EV_NONE      = 3'd0;
  localparam key_event_t EV_CHAR      = 3'd1;
  localparam key_event_t EV_ENTER     = 3'd2;
  localparam key_event_t EV_BACKSPACE = 3'd3;
  localparam key_event_t EV_DELETE    = 3'd4;
  localparam key_event_t EV_LEFT      = 3'd5;
  localparam key_event_t EV_RIGHT     = 3'd6;
  localparam key_event_t EV_EXIT      = 3'd7;

  localparam char_t CH_PRINTABLE_MIN = 8'h20;
  localparam char_t CH_LOWER_A       = 8'h61;
  localparam char_t CH_LOWER_Z       = 8'h7A;
  localparam char_t CH_LOWER_ARING   = 8'h86;
  localparam char_t CH_LOWER_AE      = 8'h91;

  localparam char_t PLAIN_MAP [TableLen] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
    8'h39, 8'h30, 8'h2B, 8'h5C, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
    8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h86, 8'h5E, 8'h0A, 8'h00,
    8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'hF8,
    8'h91, 8'h7C, 8'h00, 8'h27, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
    8'h6D, 8'h2C, 8'h2E, 8'h2D, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h37, 8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B,
    8'h31, 8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h3C, 8'h00, 8'h00
  };

  localparam char_t SHIFT_MAP [TableLen] = '{
    8'h00, 8'h1B, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h2F, 8'h28,
    8'h29, 8'h3D, 8'h3F, 8'h60, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
    8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h8F, 8'h2A, 8'h0A, 8'h00,
    8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'hF8,
    8'h92, 8'h15, 8'h00, 8'h5C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
    8'h4D, 8'h3B, 8'h3A, 8'h5F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h37, 8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B,
    8'h31, 8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h3E, 8'h00, 8'h00
  };

endpackage

// ===== sv/keyboard_scancode_decoder.sv =====
// ----------------------------------------------------------------------------
// keyboard_scancode_decoder
// Set-1 scancode to key event decoder with Nordic CP437 layout, tracking
// shift, control and caps lock.
//
//   channel  dir  tdata fields (low bit first)          width
//   s_axis   in   scancode[7:0]                          8
//   m_axis   out  key_event[2:0], character[10:3]        16
//
// One beat per cycle sustained while the output is not stalled; an input beat
// passes the input register, then is decoded into the result register.
// The modifier and caps lock flags update as a beat enters the result register.
// Reset clears both valid flags and all modifier flags.
// A stalled output holds its beat; the input register holds while it cannot
// advance, and s_axis_tready_o drops only when both stages are full.
// ----------------------------------------------------------------------------
module keyboard_scancode_decoder (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [ksd_pkg::InDataWidth-1:0]     s_axis_tdata_i,  // scancode[7:0]
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [ksd_pkg::OutDataWidth-1:0]    m_axis_tdata_o   // key_event[2:0], character[10:3]
);

  logic                 in_valid_q;
  ksd_pkg::scancode_t   sc_q;
  logic                 out_valid_q;
  ksd_pkg::key_event_t  event_q, event_d;
  ksd_pkg::char_t       char_q, char_d;

  logic lshift_q, lshift_d;
  logic rshift_q, rshift_d;
  logic lctrl_q, lctrl_d;
  logic caps_q, caps_d;

  logic out_adv;
  logic in_adv;

  logic [ksd_pkg::TableIdxW-1:0] idx;
  logic                          in_table;
  ksd_pkg::char_t                base;
  ksd_pkg::char_t                shifted;
  ksd_pkg::char_t                ch;
  logic                          is_letter;
  logic                          use_shift;

  assign out_adv         = !out_valid_q || m_axis_tready_i;
  assign in_adv          = in_valid_q && out_adv;
  assign s_axis_tready_o = !in_valid_q || out_adv;

  assign idx      = sc_q[ksd_pkg::TableIdxW-1:0];
  assign in_table = (sc_q < ksd_pkg::ScWidth'(ksd_pkg::TableLen));
  assign base     = in_table ? ksd_pkg::PLAIN_MAP[idx] : '0;
  assign shifted  = in_table ? ksd_pkg::SHIFT_MAP[idx] : '0;

  assign is_letter = ((base >= ksd_pkg::CH_LOWER_A) && (base <= ksd_pkg::CH_LOWER_Z))
                  || (base == ksd_pkg::CH_LOWER_ARING) || (base == ksd_pkg::CH_LOWER_AE);
  assign use_shift = (lshift_q || rshift_q) ^ (is_letter && caps_q);
  assign ch        = use_shift ? shifted : base;

  always_comb begin
    lshift_d = lshift_q;
    rshift_d = rshift_q;
    lctrl_d  = lctrl_q;
    caps_d   = caps_q;
    event_d  = ksd_pkg::EV_NONE;
    char_d   = '0;
    unique case (sc_q)
      ksd_pkg::SC_LSHIFT_MAKE:  lshift_d = 1'b1;
      ksd_pkg::SC_LSHIFT_BREAK: lshift_d = 1'b0;
      ksd_pkg::SC_RSHIFT_MAKE:  rshift_d = 1'b1;
      ksd_pkg::SC_RSHIFT_BREAK: rshift_d = 1'b0;
      ksd_pkg::SC_LCTRL_MAKE:   lctrl_d  = 1'b1;
      ksd_pkg::SC_LCTRL_BREAK:  lctrl_d  = 1'b0;
      ksd_pkg::SC_CAPS_MAKE:    caps_d   = !caps_q;
      ksd_pkg::SC_ENTER_MAKE:   event_d  = ksd_pkg::EV_ENTER;
      ksd_pkg::SC_BKSP_MAKE:    event_d  = ksd_pkg::EV_BACKSPACE;
      ksd_pkg::SC_DELETE_MAKE:  event_d  = ksd_pkg::EV_DELETE;
      ksd_pkg::SC_LEFT_MAKE:    event_d  = ksd_pkg::EV_LEFT;
      ksd_pkg::SC_RIGHT_MAKE:   event_d  = ksd_pkg::EV_RIGHT;
      default: begin
        if (sc_q[ksd_pkg::ScWidth-1]) begin
          event_d = ksd_pkg::EV_NONE;
        end else if ((sc_q == ksd_pkg::SC_X_MAKE) && lctrl_q) begin
          event_d = ksd_pkg::EV_EXIT;
        end else if (ch >= ksd_pkg::CH_PRINTABLE_MIN) begin
          event_d = ksd_pkg::EV_CHAR;
          char_d  = ch;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      lshift_q    <= 1'b0;
      rshift_q    <= 1'b0;
      lctrl_q     <= 1'b0;
      caps_q      <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (out_adv) begin
        out_valid_q <= in_valid_q;
      end
      if (in_adv) begin
        lshift_q <= lshift_d;
        rshift_q <= rshift_d;
        lctrl_q  <= lctrl_d;
        caps_q   <= caps_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      sc_q <= s_axis_tdata_i[ksd_pkg::ScWidth-1:0];
    end
    if (in_adv) begin
      event_q <= event_d;
      char_q  <= char_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(ksd_pkg::OutDataWidth - ksd_pkg::EventWidth
                              - ksd_pkg::CharWidth){1'b0}}, char_q, event_q};

  a_char_only_on_char_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (event_q != ksd_pkg::EV_CHAR)) |-> (char_q == '0))
    else $error("character set without a character event");

  a_char_printable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (event_q == ksd_pkg::EV_CHAR)) |-> (char_q >= ksd_pkg::CH_PRINTABLE_MIN))
    else $error("nonprintable character emitted");

  a_flags_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_adv |=> $stable({lshift_q, rshift_q, lctrl_q, caps_q}))
    else $error("modifier flags changed without a beat");

  a_caps_toggle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_adv && (sc_q == ksd_pkg::SC_CAPS_MAKE)) |=> (caps_q != $past(caps_q)))
    else $error("caps lock did not toggle");

  a_stage_full_holds_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |=> (out_valid_q && $stable(m_axis_tdata_o)))
    else $error("stalled result register changed");

endmodule
